// ===== src/msc_pkg.sv =====
// ============================================================================
// msc_pkg
// Types and constants shared by the message id cache modules.
// ============================================================================
package msc_pkg;

   localparam int KEY_W    = 160;
   localparam int SOCK_W   = 16;
   localparam int LIFE_W   = 16;
   localparam int TIMER_W  = 17;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   typedef logic [2:0] action_type;

   localparam action_type ACT_CHECK_INSERT   = 3'd0;
   localparam action_type ACT_FOUND_NEIGHBOR = 3'd1;
   localparam action_type ACT_FIND_MINE      = 3'd2;
   localparam action_type ACT_SET_CHECK      = 3'd3;
   localparam action_type ACT_FIND_SOCKET    = 3'd4;
   localparam action_type ACT_PURGE_OWNED    = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_MSG_LIFETIME = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JOIN_TIMEOUT = 1'd1;

   localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd30;
   localparam logic [LIFE_W-1:0] JOIN_RESET     = 16'd15;

   localparam logic [TIMER_W-1:0] TIMER_IDLE = '1;

   typedef struct packed {
      action_type        action;
      logic [63:0]       id_high;
      logic [63:0]       id_middle;
      logic [31:0]       id_low;
      logic              is_mine;
      logic [SOCK_W-1:0] socket_in;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic              table_full;
      logic [SOCK_W-1:0] socket_out;
   } rsp_type;

   // per-slot record, apart from the key
   typedef struct packed {
      logic               valid;
      logic               owned;
      logic               beacon;
      logic [SOCK_W-1:0]  socket;
      logic [LIFE_W-1:0]  time_left;
      logic [TIMER_W-1:0] check_timer;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic clear_en;
      logic req_load;
      logic scan_step;
      logic insert_en;
      logic rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic last_addr;
      logic rsp_busy;
   } dp_stat_type;

endpackage

// ===== src/msc_ram.sv =====
// ============================================================================
// msc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
module msc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/msc_ctrl.sv =====
// ============================================================================
// msc_ctrl
// Sequencer: clearing pass, request accept, table scan, drain, insert, result load.
// ============================================================================
module msc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  msc_pkg::dp_stat_type stat,
   output msc_pkg::ctl_cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_INSERT = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.last_addr) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         // last compare happens here
         ST_DRAIN: begin
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            cmd.insert_en = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/msc_datapath.sv =====
// ============================================================================
// msc_datapath
// Request register, key and record memories, scan compare stage, result
// register and configuration registers.
// ============================================================================
module msc_datapath #(
   parameter int ENTRIES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  msc_pkg::ctl_cmd_type                cmd,
   output msc_pkg::dp_stat_type                stat,
   input  msc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output msc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [msc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [msc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW = $clog2(ENTRIES);

   msc_pkg::req_type req_ff;

   logic [msc_pkg::LIFE_W-1:0] lifetime_ff;
   logic [msc_pkg::LIFE_W-1:0] join_ff;

   logic [AW-1:0] addr_ff, addr_in;
   logic          cmp_ff;
   logic [AW-1:0] cmp_idx_ff;

   logic                       match_ff;
   logic                       owned_match_ff;
   logic [msc_pkg::SOCK_W-1:0] sock_ff;
   logic                       free_found_ff;
   logic [AW-1:0]              free_idx_ff;
   logic                       drop_ff;

   logic             rsp_valid_ff;
   msc_pkg::rsp_type rsp_ff, rsp_in;

   logic [msc_pkg::KEY_W-1:0] req_key;
   logic [msc_pkg::KEY_W-1:0] key_rd;
   msc_pkg::rec_type          rec_rd;
   msc_pkg::rec_type          rec_upd;
   msc_pkg::rec_type          rec_new;
   msc_pkg::rec_type          rec_wr;
   logic                      key_hit;
   logic                      cmp_wr;
   logic                      purge_hit;
   logic                      need_insert;
   logic                      ins_wr;
   logic                      rec_we;
   logic [AW-1:0]             rec_waddr;

   assign req_key = {req_ff.id_high, req_ff.id_middle, req_ff.id_low};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= msc_pkg::LIFETIME_RESET;
         join_ff     <= msc_pkg::JOIN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            msc_pkg::CSR_MSG_LIFETIME: lifetime_ff <= csr_wdata;
            msc_pkg::CSR_JOIN_TIMEOUT: join_ff     <= csr_wdata;
         endcase
      end
   end

   // scan address
   always_comb begin
      addr_in = addr_ff;
      if (cmd.req_load) begin
         addr_in = '0;
      end else if (cmd.clear_en || cmd.scan_step) begin
         addr_in = addr_ff + AW'(1);
      end
   end

   assign stat.last_addr = (addr_ff == AW'(ENTRIES - 1));
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         cmp_ff  <= 1'b0;
      end else begin
         addr_ff <= addr_in;
         cmp_ff  <= cmd.scan_step;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= addr_ff;
      if (cmd.req_load) begin
         req_ff <= req_data;
      end
   end

   // compare stage: one slot per cycle
   assign key_hit   = rec_rd.valid && (key_rd == req_key);
   assign purge_hit = rec_rd.valid && rec_rd.owned;

   always_comb begin
      rec_upd = rec_rd;
      cmp_wr  = 1'b0;
      case (req_ff.action)
         msc_pkg::ACT_FOUND_NEIGHBOR: begin
            if (key_hit && rec_rd.owned) begin
               rec_upd.beacon = 1'b1;
               cmp_wr         = 1'b1;
            end
         end
         msc_pkg::ACT_SET_CHECK: begin
            if (key_hit) begin
               rec_upd.check_timer = {1'b0, join_ff};
               rec_upd.beacon      = 1'b0;
               cmp_wr              = 1'b1;
            end
         end
         msc_pkg::ACT_PURGE_OWNED: begin
            if (purge_hit) begin
               rec_upd.valid = 1'b0;
               cmp_wr        = 1'b1;
            end
         end
         default: begin
            cmp_wr = 1'b0;
         end
      endcase
      cmp_wr = cmp_wr && cmp_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         match_ff       <= 1'b0;
         owned_match_ff <= 1'b0;
         sock_ff        <= '0;
         free_found_ff  <= 1'b0;
         free_idx_ff    <= '0;
         drop_ff        <= 1'b0;
      end else if (cmp_ff) begin
         if (key_hit) begin
            match_ff       <= 1'b1;
            owned_match_ff <= rec_rd.owned;
            sock_ff        <= rec_rd.socket;
         end
         // keep the lowest free slot
         if (!rec_rd.valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= cmp_idx_ff;
         end
         if (purge_hit && req_ff.action == msc_pkg::ACT_PURGE_OWNED) begin
            drop_ff <= 1'b1;
         end
      end
   end

   // check-insert: insert after a full scan without a match, when a free slot was found
   assign need_insert = (req_ff.action == msc_pkg::ACT_CHECK_INSERT) && !match_ff &&
                        free_found_ff;
   assign ins_wr      = cmd.insert_en && need_insert;

   always_comb begin
      rec_new             = '0;
      rec_new.valid       = 1'b1;
      rec_new.owned       = req_ff.is_mine;
      rec_new.beacon      = 1'b0;
      rec_new.socket      = req_ff.socket_in;
      rec_new.time_left   = lifetime_ff;
      rec_new.check_timer = msc_pkg::TIMER_IDLE;
   end

   always_comb begin
      rec_we    = cmd.clear_en || ins_wr || cmp_wr;
      rec_waddr = cmp_idx_ff;
      rec_wr    = rec_upd;
      if (cmd.clear_en) begin
         rec_waddr = addr_ff;
         rec_wr    = '0;
      end else if (ins_wr) begin
         rec_waddr = free_idx_ff;
         rec_wr    = rec_new;
      end
   end

   msc_ram #(
      .WIDTH (msc_pkg::KEY_W),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ins_wr),
      .wr_addr (free_idx_ff),
      .wr_data (req_key),
      .rd_addr (addr_ff),
      .rd_data (key_rd)
   );

   msc_ram #(
      .WIDTH (msc_pkg::REC_W),
      .DEPTH (ENTRIES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wr),
      .rd_addr (addr_ff),
      .rd_data (rec_rd)
   );

   // result
   always_comb begin
      rsp_in = '0;
      case (req_ff.action)
         msc_pkg::ACT_CHECK_INSERT: begin
            rsp_in.hit        = match_ff;
            rsp_in.table_full = !match_ff && !free_found_ff;
         end
         msc_pkg::ACT_FOUND_NEIGHBOR,
         msc_pkg::ACT_FIND_MINE: begin
            rsp_in.hit = match_ff && owned_match_ff;
         end
         msc_pkg::ACT_SET_CHECK: begin
            rsp_in.hit = match_ff;
         end
         msc_pkg::ACT_FIND_SOCKET: begin
            rsp_in.hit        = match_ff;
            rsp_in.socket_out = match_ff ? sock_ff : '0;
         end
         msc_pkg::ACT_PURGE_OWNED: begin
            rsp_in.hit = drop_ff;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/message_id_seen_cache.sv =====
// A request that transfers scans all slots, one slot per cycle through the record and
// key memory read ports; then the last compare drains, an insert may follow and the
// result is loaded once no earlier result is pending; the next request is taken only
// after that load. Reset: a clearing pass invalidates every slot; requests are held
// off until it ends, configuration writes are taken throughout.
// ============================================================================
// message_id_seen_cache
// Bounded table of 160-bit message ids for duplicate suppression.
// ============================================================================
module message_id_seen_cache #(
   parameter int ENTRIES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  msc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output msc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_write,
   input  logic [msc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [msc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   msc_pkg::ctl_cmd_type cmd;
   msc_pkg::dp_stat_type stat;

   msc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   msc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // a result must never overwrite one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !stat.rsp_busy)
      else $error("result loaded over a pending one");

   // clearing pass never shares the write port with insert or scan
   a_wr_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_en && (cmd.insert_en || cmd.scan_step)))
      else $error("clear overlaps scan or insert");

   // once a request transfers, no other is taken before its result is loaded
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // a transferred result is retired unless a new one is loaded
   a_rsp_retire: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !cmd.rsp_load) |=> !rsp_valid)
      else $error("result not retired after transfer");

endmodule
